// ===== src/sdbe_pkg.sv =====
// ----------------------------------------------------------------------------
// sdbe_pkg
// Types, codes and constants shared by the stillness detector and its
// bias divider.
// ----------------------------------------------------------------------------
package sdbe_pkg;

   // Request and response payloads
   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } sdbe_req_type;

   typedef struct packed {
      logic [1:0]         motion_state;
      logic signed [15:0] bias_x;
      logic signed [15:0] bias_y;
      logic signed [15:0] bias_z;
      logic               bias_updated;
   } sdbe_rsp_type;

   // Divider start request
   typedef struct packed {
      logic               start;
      logic signed [23:0] dividend;
      logic [7:0]         divisor;
   } sdbe_div_req_type;

   // Motion phase codes
   localparam logic [1:0] PH_MOVING = 2'd0;
   localparam logic [1:0] PH_WAIT   = 2'd1;
   localparam logic [1:0] PH_CAL    = 2'd2;
   localparam logic [1:0] PH_STILL  = 2'd3;

   // Register indexes
   localparam logic [1:0] REG_THRESH_X    = 2'd0;
   localparam logic [1:0] REG_THRESH_Y    = 2'd1;
   localparam logic [1:0] REG_THRESH_Z    = 2'd2;
   localparam logic [1:0] REG_STILL_COUNT = 2'd3;

   // Register reset values
   localparam logic [15:0] THRESH_X_RST    = 16'd100;
   localparam logic [15:0] THRESH_Y_RST    = 16'd200;
   localparam logic [15:0] THRESH_Z_RST    = 16'd100;
   localparam logic [7:0]  STILL_COUNT_RST = 8'd3;

   // One quotient bit per divider step
   localparam int DIV_STEPS = 24;

   // Largest counter value the quiet rules can reach (2 * 255)
   localparam logic [9:0] QUIET_MAX = 10'd510;

endpackage

// ===== src/sdbe_div.sv =====
// ----------------------------------------------------------------------------
// sdbe_div
// Shared restoring divider: signed 24-bit sum over unsigned 8-bit count,
// truncated toward zero and saturated to 16 bits, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module sdbe_div
   import sdbe_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  sdbe_div_req_type   div_req,
   output logic               div_busy,
   output logic               div_done,
   output logic signed [15:0] div_quot
);

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic        neg_ff, neg_in;
   logic [7:0]  dvsr_ff, dvsr_in;
   logic [7:0]  rem_ff, rem_in;
   logic [23:0] quo_ff, quo_in;
   logic [4:0]  cnt_ff, cnt_in;

   logic [23:0] mag;
   logic [8:0]  trial;
   logic [8:0]  diff;
   logic        ge;
   logic        last;

   // Take the magnitude of the dividend
   assign mag = div_req.dividend[23] ? 24'(-div_req.dividend) : div_req.dividend;

   // One restoring step
   assign trial = {rem_ff, quo_ff[23]};
   assign diff  = trial - {1'b0, dvsr_ff};
   assign ge    = (trial >= {1'b0, dvsr_ff});
   assign last  = (cnt_ff == 5'(DIV_STEPS - 1));

   // Sequence the steps
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      neg_in  = neg_ff;
      dvsr_in = dvsr_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         neg_in  = div_req.dividend[23];
         dvsr_in = div_req.divisor;
         rem_in  = '0;
         quo_in  = mag;
         cnt_in  = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[7:0] : trial[7:0];
         quo_in = {quo_ff[22:0], ge};
         cnt_in = 5'(cnt_ff + 5'd1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      neg_ff  <= neg_in;
      dvsr_ff <= dvsr_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      cnt_ff  <= cnt_in;
   end

   // Restore sign and saturate
   always_comb begin
      if (neg_ff) begin
         if (quo_ff > 24'd32768) begin
            div_quot = 16'sh8000;
         end else begin
            div_quot = 16'(-quo_ff[15:0]);
         end
      end else begin
         if (quo_ff > 24'd32767) begin
            div_quot = 16'sh7FFF;
         end else begin
            div_quot = quo_ff[15:0];
         end
      end
   end

   assign div_busy = busy_ff;
   assign div_done = done_ff;

endmodule

// ===== src/stillness_detect_bias_estimator.sv =====
// ----------------------------------------------------------------------------
// stillness_detect_bias_estimator
// Stillness detector with accelerometer bias estimation over N quiet samples.
// ----------------------------------------------------------------------------
// Response: registered, in the cycle after the request for most samples; a bias
//   update holds it until the shared divider has run for all three axes in turn.
// Throughput: one request a cycle while no update runs and the response slot
//   is free; the divider, shared by the three axes, sets the update time.
// Reset: synchronous, clears state, sums and biases; registers take defaults.
module stillness_detect_bias_estimator
   import sdbe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  sdbe_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output sdbe_rsp_type rsp_data,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [3:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DIV  = 2'b10
   } state_type;

   state_type          state_ff, state_in;
   logic [15:0]        thresh_x_ff, thresh_y_ff, thresh_z_ff;
   logic [7:0]         still_count_ff;
   sdbe_req_type       prev_ff, prev_in;
   logic [9:0]         quiet_ff, quiet_in;
   logic [1:0]         phase_ff, phase_in;
   logic signed [23:0] sum_ff [3];
   logic signed [23:0] sum_in [3];
   logic signed [15:0] bias_ff [3];
   logic [1:0]         axis_ff, axis_in;
   logic               rsp_valid_ff, rsp_valid_in;
   sdbe_rsp_type       rsp_ff, rsp_in;

   logic               accept;
   logic               csr_wr;
   logic [7:0]         n_eff;
   logic [9:0]         two_n;
   logic signed [16:0] dx, dy, dz;
   logic [16:0]        ax_abs, ay_abs, az_abs;
   logic               motion;
   logic               need_div;
   logic               bias_wr;
   sdbe_div_req_type   div_req;
   logic               div_busy;
   logic               div_done;
   logic signed [15:0] div_quot;

   assign accept = req_valid && req_ready;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_x_ff    <= THRESH_X_RST;
         thresh_y_ff    <= THRESH_Y_RST;
         thresh_z_ff    <= THRESH_Z_RST;
         still_count_ff <= STILL_COUNT_RST;
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_THRESH_X:    thresh_x_ff    <= csr_pwdata[15:0];
            REG_THRESH_Y:    thresh_y_ff    <= csr_pwdata[15:0];
            REG_THRESH_Z:    thresh_z_ff    <= csr_pwdata[15:0];
            REG_STILL_COUNT: still_count_ff <= csr_pwdata[7:0];
            default: ;
         endcase
      end
   end

   // Register readback
   always_comb begin
      unique case (csr_paddr[3:2])
         REG_THRESH_X:    csr_prdata = {16'd0, thresh_x_ff};
         REG_THRESH_Y:    csr_prdata = {16'd0, thresh_y_ff};
         REG_THRESH_Z:    csr_prdata = {16'd0, thresh_z_ff};
         REG_STILL_COUNT: csr_prdata = {24'd0, still_count_ff};
         default:         csr_prdata = '0;
      endcase
   end

   assign csr_pready = 1'b1;

   // Motion test against the previous sample
   assign dx     = 17'(req_data.accel_x) - 17'(prev_ff.accel_x);
   assign dy     = 17'(req_data.accel_y) - 17'(prev_ff.accel_y);
   assign dz     = 17'(req_data.accel_z) - 17'(prev_ff.accel_z);
   assign ax_abs = dx[16] ? 17'(-dx) : dx;
   assign ay_abs = dy[16] ? 17'(-dy) : dy;
   assign az_abs = dz[16] ? 17'(-dz) : dz;
   assign motion = (ax_abs > {1'b0, thresh_x_ff}) || (ay_abs > {1'b0, thresh_y_ff})
                || (az_abs > {1'b0, thresh_z_ff});

   assign n_eff = (still_count_ff == 8'd0) ? 8'd1 : still_count_ff;
   assign two_n = {1'b0, n_eff, 1'b0};

   // Quiet-phase rules and the sequencer
   always_comb begin
      state_in     = state_ff;
      prev_in      = prev_ff;
      quiet_in     = quiet_ff;
      phase_in     = phase_ff;
      sum_in       = sum_ff;
      axis_in      = axis_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      need_div     = 1'b0;
      bias_wr      = 1'b0;
      div_req      = '0;
      div_req.divisor = n_eff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               prev_in = req_data;
               if (motion) begin
                  quiet_in = '0;
                  sum_in   = '{default: '0};
                  phase_in = PH_MOVING;
               end else if (quiet_ff < {2'd0, n_eff}) begin
                  quiet_in = 10'(quiet_ff + 10'd1);
                  phase_in = PH_WAIT;
               end else if (quiet_ff < two_n) begin
                  quiet_in  = 10'(quiet_ff + 10'd1);
                  sum_in[0] = 24'(sum_ff[0] + 24'(req_data.accel_x));
                  sum_in[1] = 24'(sum_ff[1] + 24'(req_data.accel_y));
                  sum_in[2] = 24'(sum_ff[2] + 24'(req_data.accel_z));
                  phase_in  = PH_CAL;
               end else begin
                  need_div = (phase_ff != PH_STILL);
                  phase_in = PH_STILL;
               end
               if (need_div) begin
                  // Start x; the response waits for all three axes
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_ff[0];
                  axis_in          = 2'd0;
                  state_in         = ST_DIV;
               end else begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.motion_state = phase_in;
                  rsp_in.bias_x       = bias_ff[0];
                  rsp_in.bias_y       = bias_ff[1];
                  rsp_in.bias_z       = bias_ff[2];
                  rsp_in.bias_updated = 1'b0;
               end
            end
         end
         ST_DIV: begin
            if (div_done) begin
               bias_wr = 1'b1;
               if (axis_ff == 2'd2) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.motion_state = phase_ff;
                  rsp_in.bias_x       = bias_ff[0];
                  rsp_in.bias_y       = bias_ff[1];
                  rsp_in.bias_z       = div_quot;
                  rsp_in.bias_updated = 1'b1;
                  state_in            = ST_IDLE;
               end else begin
                  axis_in          = 2'(axis_ff + 2'd1);
                  div_req.start    = 1'b1;
                  div_req.dividend = sum_ff[axis_in];
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         prev_ff      <= '0;
         quiet_ff     <= '0;
         phase_ff     <= PH_MOVING;
         sum_ff       <= '{default: '0};
         bias_ff      <= '{default: '0};
         axis_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         prev_ff      <= prev_in;
         quiet_ff     <= quiet_in;
         phase_ff     <= phase_in;
         sum_ff       <= sum_in;
         axis_ff      <= axis_in;
         rsp_valid_ff <= rsp_valid_in;
         if (bias_wr) begin
            bias_ff[axis_ff] <= div_quot;
         end
      end
      rsp_ff <= rsp_in;
   end

   // Shared divider
   sdbe_div u_div (
      .clock    (clock),
      .reset    (reset),
      .div_req  (div_req),
      .div_busy (div_busy),
      .div_done (div_done),
      .div_quot (div_quot)
   );

   // Hold requests while an update runs or the response slot is full
   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef NO_ASSERTIONS
   a_ready_div_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !div_busy)
      else $error("request taken while divider busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside update");

   a_update_still: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.bias_updated) |-> rsp_data.motion_state == PH_STILL)
      else $error("bias update without still phase");

   a_quiet_range: assert property (@(posedge clock) disable iff (reset)
      quiet_ff <= QUIET_MAX)
      else $error("quiet counter out of range");

   a_update_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && div_done && axis_ff == 2'd2) |=> rsp_valid)
      else $error("finished update gave no response");
`endif

endmodule
